FILE: hdl/tfd_pkg.sv
// ----------------------------------------------------------------------------
// tfd_pkg: shared types and constants of the tactile frame touch detector
// request payloads, configuration record, register indexes and method codes
// ----------------------------------------------------------------------------
package tfd_pkg;

    // field widths
    localparam int SAMPLE_W = 8;
    localparam int SUM_W    = 18;
    localparam int CNT_W    = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;

    // default frame size bound
    localparam int MAX_TAXELS_DEF = 1024;
    // largest value the count field holds
    localparam int COUNT_FIELD_TOP = 2047;

    // raw mode inversion reference
    localparam logic [SAMPLE_W-1:0] RAW_REFERENCE = 8'd244;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CALIBRATED_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DETECT_METHOD   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_THRESHOLD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FORCE_THRESHOLD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT_THRESHOLD = 3'd4;

    // detection methods
    localparam logic [1:0] METHOD_MAX   = 2'd0;
    localparam logic [1:0] METHOD_SUM   = 2'd1;
    localparam logic [1:0] METHOD_COUNT = 2'd2;

    // register reset values
    localparam logic [SUM_W-1:0]    LEVEL_RESET = 18'd100;
    localparam logic [SAMPLE_W-1:0] FORCE_RESET = 8'd50;
    localparam logic [CNT_W-1:0]    COUNT_RESET = 11'd5;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                last_sample;
    } t_in;

    typedef struct packed {
        logic                touched;
        logic [SAMPLE_W-1:0] frame_max;
        logic [SUM_W-1:0]    frame_sum;
        logic [CNT_W-1:0]    above_count;
    } t_out;

    typedef struct packed {
        logic                calibrated_mode;
        logic [1:0]          detect_method;
        logic [SUM_W-1:0]    level_threshold;
        logic [SAMPLE_W-1:0] force_threshold;
        logic [CNT_W-1:0]    count_threshold;
    } t_cfg;

endpackage

FILE: hdl/tfd_cfg_regs.sv
// ----------------------------------------------------------------------------
// tfd_cfg_regs: configuration register file
// write-only registers, each keeps only its own width
// ----------------------------------------------------------------------------
module tfd_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [tfd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [tfd_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output tfd_pkg::t_cfg                   o_cfg
);
    import tfd_pkg::*;

    t_cfg r_cfg;

    // register writes, unknown indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.calibrated_mode <= 1'b0;
            r_cfg.detect_method   <= METHOD_MAX;
            r_cfg.level_threshold <= LEVEL_RESET;
            r_cfg.force_threshold <= FORCE_RESET;
            r_cfg.count_threshold <= COUNT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CALIBRATED_MODE: r_cfg.calibrated_mode <= i_cfg_data[0];
                CFG_DETECT_METHOD:   r_cfg.detect_method   <= i_cfg_data[1:0];
                CFG_LEVEL_THRESHOLD: r_cfg.level_threshold <= i_cfg_data[SUM_W-1:0];
                CFG_FORCE_THRESHOLD: r_cfg.force_threshold <= i_cfg_data[SAMPLE_W-1:0];
                CFG_COUNT_THRESHOLD: r_cfg.count_threshold <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: hdl/tfd_frame_accum.sv
// ----------------------------------------------------------------------------
// tfd_frame_accum: sample conditioning and frame accumulators
// running max, saturating sum and count, with the touch decision per frame
// ----------------------------------------------------------------------------
module tfd_frame_accum #(
    parameter int MAX_TAXELS = tfd_pkg::MAX_TAXELS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_step,
    input  tfd_pkg::t_in   i_item,
    input  tfd_pkg::t_cfg  i_cfg,
    output tfd_pkg::t_out  o_result
);
    import tfd_pkg::*;

    localparam int CAP_INT = (MAX_TAXELS < COUNT_FIELD_TOP) ? MAX_TAXELS : COUNT_FIELD_TOP;
    localparam logic [CNT_W-1:0] COUNT_CAP = CNT_W'(CAP_INT);

    logic [SAMPLE_W-1:0] r_max, n_max;
    logic [SUM_W-1:0]    r_sum, n_sum;
    logic [CNT_W-1:0]    r_count, n_count;

    logic [SAMPLE_W-1:0] w_value;
    logic [SUM_W:0]      w_sum_ext;
    logic                w_touched;

    // conditioning: pass through, or inverted against the reference (zero above it)
    always_comb begin
        if (i_cfg.calibrated_mode) begin
            w_value = i_item.sample;
        end else if (i_item.sample <= RAW_REFERENCE) begin
            w_value = RAW_REFERENCE - i_item.sample;
        end else begin
            w_value = '0;
        end
    end

    // updated statistics including this sample
    always_comb begin
        n_max     = (w_value > r_max) ? w_value : r_max;
        w_sum_ext = {1'b0, r_sum} + {{(SUM_W + 1 - SAMPLE_W){1'b0}}, w_value};
        n_sum     = w_sum_ext[SUM_W] ? {SUM_W{1'b1}} : w_sum_ext[SUM_W-1:0];
        n_count   = r_count;
        if (w_value > i_cfg.force_threshold && r_count < COUNT_CAP) begin
            n_count = r_count + CNT_W'(1);
        end
    end

    // touch decision, unknown method never touches
    always_comb begin
        unique case (i_cfg.detect_method)
            METHOD_MAX:   w_touched = {{(SUM_W - SAMPLE_W){1'b0}}, n_max} > i_cfg.level_threshold;
            METHOD_SUM:   w_touched = n_sum > i_cfg.level_threshold;
            METHOD_COUNT: w_touched = n_count > i_cfg.count_threshold;
            default:      w_touched = 1'b0;
        endcase
    end

    assign o_result.touched     = w_touched;
    assign o_result.frame_max   = n_max;
    assign o_result.frame_sum   = n_sum;
    assign o_result.above_count = n_count;

    // accumulators, cleared after the last sample of a frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max   <= '0;
            r_sum   <= '0;
            r_count <= '0;
        end else if (i_step) begin
            if (i_item.last_sample) begin
                r_max   <= '0;
                r_sum   <= '0;
                r_count <= '0;
            end else begin
                r_max   <= n_max;
                r_sum   <= n_sum;
                r_count <= n_count;
            end
        end
    end

endmodule

FILE: hdl/tactile_frame_touch_detector.sv
// ----------------------------------------------------------------------------
// tactile_frame_touch_detector: per-frame touch detection on taxel samples
// input register, frame accumulators and an output result register
// ----------------------------------------------------------------------------
// Usage:
//   input channel carries one taxel sample and its end-of-frame mark per
//   request (i_in_valid / o_in_stall / i_in_data). A request is taken at an
//   edge with valid high and stall low.
//   output channel carries one result per frame (o_out_valid / i_out_stall /
//   o_out_data), produced from the sample marked last.
//   configuration is a plain write port (i_cfg_we, i_cfg_index, i_cfg_data);
//   the user must write it only while the block is idle; the block does not enforce it.
// Timing:
//   one sample per cycle sustained unless a last sample waits on a stalled
//   result; the accumulator update is a single compare and add between the
//   input register and the accumulators. A result is valid once its last
//   sample moves from the input register into a free result register.
// Reset:
//   synchronous active low; empties both registers, clears the accumulators
//   and loads the register defaults.
// Stall:
//   a stalled result holds; samples that end no frame keep flowing, and a
//   last sample waits in the input register until the result is taken.
// ----------------------------------------------------------------------------
module tactile_frame_touch_detector #(
    parameter int MAX_TAXELS = tfd_pkg::MAX_TAXELS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  tfd_pkg::t_in                    i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output tfd_pkg::t_out                   o_out_data,
    input  logic                            i_cfg_we,
    input  logic [tfd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [tfd_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import tfd_pkg::*;

    localparam int CAP_INT = (MAX_TAXELS < COUNT_FIELD_TOP) ? MAX_TAXELS : COUNT_FIELD_TOP;
    localparam logic [CNT_W-1:0] COUNT_CAP = CNT_W'(CAP_INT);

    t_cfg  w_cfg;
    t_out  w_result;
    t_in   r_s1;
    logic  r_s1_valid;
    t_out  r_out;
    logic  r_out_valid;
    logic  w_out_free;
    logic  w_step;
    logic  w_in_take;

    tfd_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    tfd_frame_accum #(
        .MAX_TAXELS (MAX_TAXELS)
    ) u_accum (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_item   (r_s1),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    // handshake: a last sample advances only into a free result register
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_step     = r_s1_valid && (!r_s1.last_sample || w_out_free);
    assign o_in_stall = r_s1_valid && !w_step;
    assign w_in_take  = i_in_valid && !o_in_stall;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_in_take || (r_s1_valid && !w_step);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_s1 <= i_in_data;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step && r_s1.last_sample) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && r_s1.last_sample) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // a new result only appears after a last sample advanced
    a_rise_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_step && r_s1.last_sample))
        else $error("result appeared without a last sample");

    // a held result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !(w_step && r_s1.last_sample))
        else $error("stalled result overwritten");

    // the count never passes its cap
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.above_count <= COUNT_CAP))
        else $error("above count beyond cap");

endmodule
